FILE: rtl/tpie_pkg.sv
// Shared widths, constants and control structs of the triangle pair index enumerator.
package tpie_pkg;

  localparam int MAX_STATES = 64;
  localparam int STATE_W    = 6;
  localparam int CNT_W      = 7;
  localparam int POS_W      = 11;
  localparam int REM_W      = 6;

  localparam logic [CNT_W-1:0] MIN_STATES   = CNT_W'(2);
  localparam logic [CNT_W-1:0] RESET_STATES = CNT_W'(20);

  typedef struct packed {
    logic load;
    logic adv;
  } step_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
  } step_stat_t;

endpackage

FILE: rtl/tpie_step_unit.sv
// Position walker: one shared adder steps the packed position from pair to pair.
module tpie_step_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  tpie_pkg::step_ctl_t           ctl,
  input  logic [tpie_pkg::STATE_W-1:0]  state_in,
  input  logic [tpie_pkg::CNT_W-1:0]    n_eff,
  output tpie_pkg::step_stat_t          stat
);
  import tpie_pkg::*;

  logic [POS_W-1:0]   pos;
  logic [CNT_W-1:0]   inc_dec;   // n-2-i while walking earlier rows
  logic [CNT_W-1:0]   gap;       // n-s, hop from column s to start of row s
  logic [STATE_W-1:0] rows_left;
  logic [REM_W-1:0]   remain;
  logic               ph1;

  logic [CNT_W-1:0]   addend;
  logic [POS_W-1:0]   pos_next;

  always_comb begin
    if (ph1) begin
      addend = (rows_left == STATE_W'(1)) ? gap : inc_dec;
    end else begin
      addend = CNT_W'(1);
    end
    pos_next = pos + POS_W'(addend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph1    <= 1'b0;
      remain <= '0;
    end else if (ctl.load) begin
      pos       <= (state_in == '0) ? '0 : POS_W'(state_in) - POS_W'(1);
      ph1       <= (state_in != '0);
      rows_left <= state_in;
      inc_dec   <= n_eff - CNT_W'(2);
      gap       <= n_eff - CNT_W'(state_in);
      remain    <= REM_W'(n_eff - CNT_W'(1));
    end else if (ctl.adv) begin
      pos    <= pos_next;
      remain <= remain - REM_W'(1);
      if (ph1) begin
        rows_left <= rows_left - STATE_W'(1);
        if (rows_left == STATE_W'(1)) begin
          ph1 <= 1'b0;
        end else begin
          inc_dec <= inc_dec - CNT_W'(1);
        end
      end
    end
  end

  assign stat.pos  = pos;
  assign stat.last = (remain == REM_W'(1));

endmodule

FILE: rtl/triangle_pair_index_enumerator.sv
// Top level of the triangle pair index enumerator: config register, sequencer, result register.
//
// For a state s and N states (num_states, clamped to 2..64, reset 20) the block
// emits the packed row-major upper-triangle positions of every pair holding s:
// first the pairs (i,s) with i < s in increasing i, then (s,j) with j > s in
// increasing j, N-1 results in all, the final one flagged by last. A state at or
// above N gives one result: position 0, last and bad_state set. Items are handled
// one at a time: in_ready is high only when the sequencer is idle. A valid state
// occupies the block from its transfer to the next possible input transfer: a load
// step, then one result per cycle through the position adder while out_ready
// holds high. A bad state is loaded and then sends its single result through the
// result register. Output stalls hold the sequencer in RUN. num_states is written
// through cfg_write/cfg_data and must only change while the block is idle.
module triangle_pair_index_enumerator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tpie_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tpie_pkg::STATE_W-1:0]  state_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpie_pkg::POS_W-1:0]    pair_position,
  output logic                          last,
  output logic                          bad_state
);
  import tpie_pkg::*;

  typedef enum logic {
    IDLE,
    RUN
  } seq_state_t;

  seq_state_t       state;
  logic [CNT_W-1:0] num_states;
  logic [CNT_W-1:0] n_eff;
  logic             bad_held;

  step_ctl_t        ctl;
  step_stat_t       stat;

  logic             in_xfer;
  logic             slot_free;

  // Clamp the register to the supported range of states.
  always_comb begin
    priority if (num_states < MIN_STATES) begin
      n_eff = MIN_STATES;
    end else if (num_states > CNT_W'(MAX_STATES)) begin
      n_eff = CNT_W'(MAX_STATES);
    end else begin
      n_eff = num_states;
    end
  end

  assign in_ready  = (state == IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    ctl.load = in_xfer;
    ctl.adv  = (state == RUN) && slot_free && !bad_held;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= RESET_STATES;
    end else if (cfg_write) begin
      num_states <= cfg_data;
    end
  end

  tpie_step_unit u_step (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .state_in (state_number),
    .n_eff    (n_eff),
    .stat     (stat)
  );

  // Sequencer and result register. In RUN every free slot is refilled, so the
  // result register only drains on its own while idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      bad_held  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (in_xfer) begin
            bad_held <= (CNT_W'(state_number) >= n_eff);
            state    <= RUN;
          end
        end
        RUN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (bad_held) begin
              pair_position <= '0;
              last          <= 1'b1;
              bad_state     <= 1'b1;
              state         <= IDLE;
            end else begin
              pair_position <= stat.pos;
              last          <= stat.last;
              bad_state     <= 1'b0;
              if (stat.last) begin
                state <= IDLE;
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/tpie_checker.sv
// Port-level checks of the triangle pair index enumerator, bound to the top level.
module tpie_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tpie_pkg::POS_W-1:0]    pair_position,
  input logic                          last,
  input logic                          bad_state
);
  import tpie_pkg::*;

  // A bad state result is the sole result of its item.
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_state) |-> last)
    else $error("bad_state result without last");

  a_bad_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_state) |-> (pair_position == '0))
    else $error("bad_state result with nonzero position");

  // One item at a time: busy right after an input transfer.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pair_position)
                                   && $stable(last) && $stable(bad_state)))
    else $error("stalled result changed");

endmodule

bind triangle_pair_index_enumerator tpie_checker u_tpie_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pair_position (pair_position),
  .last          (last),
  .bad_state     (bad_state)
);

FILE: test/triangle_pair_index_enumerator_tb.sv
// Self-checking testbench for the triangle pair index enumerator.
module triangle_pair_index_enumerator_tb;
  import tpie_pkg::*;

  // Longest quiet stretch of a correct run is the receiver hold-off plus some
  // random idling, well below this bound.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int IDLE_PCT       = 30;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 28;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 4;
  localparam int TAIL_CYCLES    = 2 * MAX_STATES;
  localparam int NUM_DIRECTED   = 21;

  // Phases with special treatment in the random part.
  localparam int PHASE_NO_IDLE  = 2;   // neither side idles
  localparam int PHASE_RX_HOLD  = 3;   // receiver holds off, input backs up
  localparam int PHASE_PAUSE    = 5;   // sender pauses until all results are in

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
    logic             bad;
  } pair_result_t;

  // One directed row: optional register write before the transfer, the state,
  // and, for single-result rows, the typed-in expected result.
  typedef struct packed {
    logic               wr_cfg;
    logic [CNT_W-1:0]   cfg;
    logic [STATE_W-1:0] st;
    logic               typed;
    pair_result_t       res;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // reset value of 20 states: both ends of the range, then out of range
    '{1'b0, 7'd0,   6'd0,  1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   6'd19, 1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   6'd20, 1'b1, '{11'd0, 1'b1, 1'b1}},
    '{1'b0, 7'd0,   6'd63, 1'b1, '{11'd0, 1'b1, 1'b1}},
    // smallest triangle: a single pair at position 0
    '{1'b1, 7'd2,   6'd0,  1'b1, '{11'd0, 1'b1, 1'b0}},
    '{1'b0, 7'd0,   6'd1,  1'b1, '{11'd0, 1'b1, 1'b0}},
    '{1'b0, 7'd0,   6'd2,  1'b1, '{11'd0, 1'b1, 1'b1}},
    // register below the minimum saturates to 2 states
    '{1'b1, 7'd0,   6'd1,  1'b1, '{11'd0, 1'b1, 1'b0}},
    '{1'b0, 7'd0,   6'd5,  1'b1, '{11'd0, 1'b1, 1'b1}},
    '{1'b1, 7'd1,   6'd0,  1'b1, '{11'd0, 1'b1, 1'b0}},
    // full size triangle
    '{1'b1, 7'd64,  6'd0,  1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   6'd63, 1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   6'd42, 1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   6'd21, 1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   6'd31, 1'b0, '{11'd0, 1'b0, 1'b0}},
    // register above the maximum saturates to 64 states
    '{1'b1, 7'd127, 6'd63, 1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   6'd32, 1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b1, 7'd65,  6'd1,  1'b0, '{11'd0, 1'b0, 1'b0}},
    // three states: last valid state, then first bad one
    '{1'b1, 7'd3,   6'd2,  1'b0, '{11'd0, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   6'd3,  1'b1, '{11'd0, 1'b1, 1'b1}},
    '{1'b1, 7'd20,  6'd10, 1'b0, '{11'd0, 1'b0, 1'b0}}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CNT_W-1:0]     cfg_data = RESET_STATES;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [STATE_W-1:0]   state_number = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [POS_W-1:0]     pair_position;
  logic                 last;
  logic                 bad_state;

  // Sideband held with the payload: tells the monitor to take the typed
  // result instead of the predicted one for this transfer.
  logic                 in_typed = 1'b0;
  pair_result_t         typed_result = '0;

  // Control from the stimulus process to the receiver.
  logic                 hold_req = 1'b0;
  logic                 no_idle = 1'b0;

  // Shadow of the configuration register and expected results in order.
  logic [CNT_W-1:0]     state_count_reg = RESET_STATES;
  pair_result_t         pending_pairs [$];
  int                   mismatch_count = 0;
  int                   quiet_cycles = 0;

  always #1 clk = ~clk;

  triangle_pair_index_enumerator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .state_number  (state_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pair_position (pair_position),
    .last          (last),
    .bad_state     (bad_state)
  );

  // Register value as the block uses it: saturated to 2..64.
  function automatic int clamp_state_count(input logic [CNT_W-1:0] v);
    if (v < MIN_STATES) return int'(MIN_STATES);
    if (v > MAX_STATES) return MAX_STATES;
    return int'(v);
  endfunction

  // Append one expected result at the tail of the queue.
  function automatic void queue_expected(input pair_result_t r);
    pending_pairs = {pending_pairs, r};
  endfunction

  // Expected positions for state s: column s of every earlier row, then the
  // whole row of s. Row a starts at a*n - a*(a+1)/2, built up incrementally.
  function automatic void enqueue_pair_positions(input logic [STATE_W-1:0] s);
    int n;
    int base;
    int k;
    pair_result_t r;
    n = clamp_state_count(state_count_reg);
    base = 0;
    k = 0;
    if (int'(s) >= n) begin
      r.pos  = '0;
      r.last = 1'b1;
      r.bad  = 1'b1;
      queue_expected(r);
      return;
    end
    for (int i = 0; i < int'(s); i++) begin
      r.pos  = POS_W'(base + int'(s) - i - 1);
      r.last = (k + 1 == n - 1);
      r.bad  = 1'b0;
      queue_expected(r);
      k++;
      base += n - i - 1;
    end
    for (int j = 0; j + int'(s) + 1 < n; j++) begin
      r.pos  = POS_W'(base + j);
      r.last = (k + 1 == n - 1);
      r.bad  = 1'b0;
      queue_expected(r);
      k++;
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("%s", msg);
    mismatch_count++;
  endfunction

  // Monitor: values read here are the ones before the edge, so a transfer is
  // seen exactly at the edge where it happens. Input side first, so an
  // expectation is always queued before its result could be checked.
  always @(posedge clk) begin : monitor
    pair_result_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_typed) queue_expected(typed_result);
        else enqueue_pair_positions(state_number);
      end
      if (out_valid && out_ready) begin
        if (pending_pairs.size() == 0) begin
          note_mismatch($sformatf("unexpected result: pos=%0d last=%0b bad=%0b",
                                  pair_position, last, bad_state));
        end else begin
          want = pending_pairs.pop_front();
          if (pair_position !== want.pos || last !== want.last ||
              bad_state !== want.bad) begin
            note_mismatch($sformatf(
              "result mismatch: expected pos=%0d last=%0b bad=%0b, got pos=%0d last=%0b bad=%0b",
              want.pos, want.last, want.bad, pair_position, last, bad_state));
          end
        end
      end
      // Watchdog: count cycles with no transfer on either side.
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("triangle_pair_index_enumerator_tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, none in the no-idle phase, and one long
  // hold-off, counted here, once the stimulus asks for it.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one state and hold it until the transfer.
  task automatic send_state(input logic [STATE_W-1:0] s, input logic typed,
                            input pair_result_t res);
    in_valid     <= 1'b1;
    state_number <= s;
    in_typed     <= typed;
    typed_result <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random sender gaps, about IDLE_PCT percent of cycles.
  task automatic sender_idle();
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering until every expected result is in and the block is idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pairs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_states(input logic [CNT_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    state_count_reg = v;
  endtask

  // Register value per phase: both extremes first, then mostly small
  // triangles with an occasional pick from the whole register range.
  function automatic logic [CNT_W-1:0] pick_state_count(input int phase);
    if (phase == 0) return MIN_STATES;
    if (phase == 1) return CNT_W'(MAX_STATES);
    if ($urandom_range(0, 99) < 70) return CNT_W'($urandom_range(2, 24));
    return CNT_W'($urandom_range(0, 127));
  endfunction

  // Mostly valid states, some past the end, some anywhere.
  function automatic logic [STATE_W-1:0] pick_state();
    int n;
    int r;
    n = clamp_state_count(state_count_reg);
    r = $urandom_range(0, 99);
    if (r < 80) return STATE_W'($urandom_range(0, n - 1));
    if (r < 90 && n < MAX_STATES) return STATE_W'($urandom_range(n, MAX_STATES - 1));
    return STATE_W'($urandom_range(0, MAX_STATES - 1));
  endfunction

  initial begin : stimulus
    pair_result_t none;
    none = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].wr_cfg) begin
        wait_drained();
        write_states(DIRECTED_ROWS[i].cfg);
      end
      send_state(DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      sender_idle();
    end

    // Random phases, each under a fresh register value.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_states(pick_state_count(p));
      no_idle <= (p == PHASE_NO_IDLE);
      if (p == PHASE_RX_HOLD) hold_req <= 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == PHASE_PAUSE && k == PHASE_ITEMS / 2) wait_drained();
        send_state(pick_state(), 1'b0, none);
        sender_idle();
      end
    end

    // Drain, then leave room for any stray result to show up.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pairs.size() == 0) begin
      $display("triangle_pair_index_enumerator_tb OK");
    end else begin
      $display("triangle_pair_index_enumerator_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: triangle_pair_index_enumerator.f
rtl/tpie_pkg.sv
rtl/tpie_step_unit.sv
rtl/triangle_pair_index_enumerator.sv
rtl/tpie_checker.sv
test/triangle_pair_index_enumerator_tb.sv
